FILE: hdl/mi3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared types and constant tables for the 3x3 matrix inverse.
// ---------------------------------------------------------------------------
package mi3_pkg;

  // per-lane control that travels beside a quotient through the divider
  typedef struct packed {
    logic neg;   // quotient sign
    logic zero;  // force the result to zero (singular matrix)
  } mi3_flag_t;

  // adjugate entry k = m[a]*m[b] - m[c]*m[d], elements in column-major order
  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  // elements of the first row, used for the determinant expansion
  localparam int unsigned ROW0_IDX [3] = '{0, 3, 6};

endpackage
`default_nettype wire

FILE: hdl/mi3_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mi3_div
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detection in the input stage, sign restore and saturation in the last stage.
// ---------------------------------------------------------------------------
module mi3_div
  import mi3_pkg::*;
#(
  parameter int NW = 97,
  parameter int DW = 99,
  parameter int QW = 32
) (
  input  wire logic                 clk,
  input  wire logic [NW-1:0]        n_mag,
  input  wire logic [DW-1:0]        d_mag,
  input  wire mi3_flag_t            flag,
  output      logic signed [QW-1:0] q
);

  localparam int RW = DW + QW;

  logic [RW-1:0] rem [QW+1];
  logic [DW-1:0] den [QW+1];
  logic [QW-1:0] quo [QW+1];
  mi3_flag_t     flg [QW+1];
  logic          ovf [QW+1];

  // quotient overflows the field when n >= d * 2^QW
  always_ff @(posedge clk) begin
    rem[0] <= RW'(n_mag);
    den[0] <= d_mag;
    quo[0] <= '0;
    flg[0] <= flag;
    ovf[0] <= (RW'(n_mag) >= {d_mag, QW'(0)});
  end

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [RW-1:0] dsh;
    logic          fit;
    assign dsh = RW'(den[s]) << (QW - 1 - s);
    assign fit = (rem[s] >= dsh);
    always_ff @(posedge clk) begin
      rem[s+1] <= fit ? (rem[s] - dsh) : rem[s];
      quo[s+1] <= quo[s] | (fit ? (QW'(1) << (QW - 1 - s)) : '0);
      den[s+1] <= den[s];
      flg[s+1] <= flg[s];
      ovf[s+1] <= ovf[s];
    end
  end

  localparam logic [QW-1:0] TOPBIT = QW'(1) << (QW - 1);

  always_ff @(posedge clk) begin
    if (flg[QW].zero) begin
      q <= '0;
    end else if (flg[QW].neg) begin
      q <= (ovf[QW] || quo[QW] > TOPBIT) ? $signed(TOPBIT) : -$signed(quo[QW]);
    end else begin
      q <= (ovf[QW] || quo[QW][QW-1]) ? $signed(~TOPBIT) : $signed(quo[QW]);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/matrix_inverse_3x3.sv
`default_nettype none
// ---------------------------------------------------------------------------
// matrix_inverse_3x3
// 3x3 matrix inverse by the adjugate, exact fixed point, fully pipelined.
// ---------------------------------------------------------------------------
// One matrix beat is taken per cycle (busy is high only while rst is held) and
// its result beat appears on the outputs, marked by done, once it has passed
// the cofactor, determinant and divider stages. Throughput is one matrix per
// clock.
// In the divider, each of the nine inverse lanes resolves one quotient bit per
// stage, ELEM_WIDTH stages, plus an overflow check and a saturation stage;
// seven stages ahead of it form the cofactors and the exact determinant.
// Results are shown for one cycle only and cannot be held off,
// so the consumer must take every done beat. A zero determinant sets singular
// and forces all inverse elements (and det_out) to zero. Quotients truncate
// toward zero and saturate to the element range.
// ---------------------------------------------------------------------------
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r0c0,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r1c0,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r2c0,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r0c1,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r1c1,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r2c1,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r0c2,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r1c2,
  input  wire logic signed [ELEM_WIDTH-1:0] a_r2c2,
  output      logic                         done,
  output      logic signed [ELEM_WIDTH-1:0] inv_r0c0,
  output      logic signed [ELEM_WIDTH-1:0] inv_r1c0,
  output      logic signed [ELEM_WIDTH-1:0] inv_r2c0,
  output      logic signed [ELEM_WIDTH-1:0] inv_r0c1,
  output      logic signed [ELEM_WIDTH-1:0] inv_r1c1,
  output      logic signed [ELEM_WIDTH-1:0] inv_r2c1,
  output      logic signed [ELEM_WIDTH-1:0] inv_r0c2,
  output      logic signed [ELEM_WIDTH-1:0] inv_r1c2,
  output      logic signed [ELEM_WIDTH-1:0] inv_r2c2,
  output      logic signed [ELEM_WIDTH-1:0] det_out,
  output      logic                         singular
);

  localparam int W   = ELEM_WIDTH;
  localparam int AW  = 2 * W + 1;          // adjugate entry
  localparam int DW  = 3 * W + 3;          // determinant
  localparam int NW  = AW + 2 * FRAC_BITS; // scaled numerator magnitude
  localparam int LAT = W + 9;              // start to done

  // fully pipelined: only reset holds the sender off
  assign busy = rst;

  // valid bits travel with the data
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end
  assign done = vld[LAT-1];

  // s1: input register
  logic signed [W-1:0] m1 [9];
  always_ff @(posedge clk) begin
    m1[0] <= a_r0c0; m1[1] <= a_r1c0; m1[2] <= a_r2c0;
    m1[3] <= a_r0c1; m1[4] <= a_r1c1; m1[5] <= a_r2c1;
    m1[6] <= a_r0c2; m1[7] <= a_r1c2; m1[8] <= a_r2c2;
  end

  // s2: cofactor products, s3: cofactor differences
  logic signed [2*W-1:0] pa [9];
  logic signed [2*W-1:0] pb [9];
  logic signed [AW-1:0]  adj3 [9];
  logic signed [AW-1:0]  adj4 [9];
  logic signed [AW-1:0]  adj5 [9];
  logic signed [AW-1:0]  adj6 [9];

  for (genvar k = 0; k < 9; k++) begin : g_cof
    always_ff @(posedge clk) begin
      pa[k]   <= m1[COF_IDX[k][0]] * m1[COF_IDX[k][1]];
      pb[k]   <= m1[COF_IDX[k][2]] * m1[COF_IDX[k][3]];
      adj3[k] <= AW'(pa[k]) - AW'(pb[k]);
      adj4[k] <= adj3[k];
      adj5[k] <= adj4[k];
      adj6[k] <= adj5[k];
    end
  end

  // first-row elements delayed to line up with adj3
  logic signed [W-1:0] m2 [3];
  logic signed [W-1:0] m3 [3];

  // s4: first-row element times adjugate, the adjugate split into two ~W-bit halves
  logic signed [2*W:0]   plo [3];
  logic signed [2*W:0]   phi [3];
  logic signed [DW-1:0]  term [3];

  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      m2[j]   <= m1[ROW0_IDX[j]];
      m3[j]   <= m2[j];
      plo[j]  <= m3[j] * $signed({1'b0, adj3[j][W-1:0]});
      phi[j]  <= m3[j] * $signed(adj3[j][AW-1:W]);
      term[j] <= (DW'(phi[j]) <<< W) + DW'(plo[j]);
    end
  end

  // s6: exact determinant
  logic signed [DW-1:0] det6;
  always_ff @(posedge clk) begin
    det6 <= term[0] + term[1] + term[2];
  end

  // s7: magnitudes, signs, singular test and det_out
  logic                   dneg;
  logic [DW-1:0]          dmag;
  logic [DW-1:0]          dsh;
  logic [DW-1:0]          dtop;
  logic signed [W-1:0]    det_sat;
  logic [DW-1:0]          dmag7;
  logic [NW-1:0]          nmag7 [9];
  mi3_flag_t              flag7 [9];
  logic signed [W-1:0]    dp [W+3];
  logic                   sp [W+3];

  always_comb begin
    dneg = det6[DW-1];
    dmag = dneg ? DW'(-det6) : DW'(det6);
    dsh  = dmag >> (2 * FRAC_BITS);
    dtop = DW'(1) << (W - 1);
    if (dneg) begin
      det_sat = (dsh > dtop) ? $signed(W'(dtop)) : -$signed(W'(dsh));
    end else begin
      det_sat = (dsh >= dtop) ? $signed(~W'(dtop)) : $signed(W'(dsh));
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_abs
    always_ff @(posedge clk) begin
      nmag7[k]      <= {(adj6[k][AW-1] ? AW'(-adj6[k]) : AW'(adj6[k])),
                        (2 * FRAC_BITS)'(0)};
      flag7[k].neg  <= adj6[k][AW-1] ^ dneg;
      flag7[k].zero <= (det6 == '0);
    end
  end

  always_ff @(posedge clk) begin
    dmag7 <= dmag;
    dp[0] <= det_sat;
    sp[0] <= (det6 == '0);
  end

  // det_out and singular ride alongside the divider stages
  for (genvar s = 0; s < W + 2; s++) begin : g_dline
    always_ff @(posedge clk) begin
      dp[s+1] <= dp[s];
      sp[s+1] <= sp[s];
    end
  end
  assign det_out  = dp[W+2];
  assign singular = sp[W+2];

  // nine divider lanes: inverse = adj * 2^(2F) / det
  logic signed [W-1:0] q [9];
  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div #(.NW(NW), .DW(DW), .QW(W)) u_div (
      .clk   (clk),
      .n_mag (nmag7[k]),
      .d_mag (dmag7),
      .flag  (flag7[k]),
      .q     (q[k])
    );
  end

  assign inv_r0c0 = q[0];
  assign inv_r1c0 = q[1];
  assign inv_r2c0 = q[2];
  assign inv_r0c1 = q[3];
  assign inv_r1c1 = q[4];
  assign inv_r2c1 = q[5];
  assign inv_r0c2 = q[6];
  assign inv_r1c2 = q[7];
  assign inv_r2c2 = q[8];

`ifndef ASSERT_OFF
  a_lat : assert property (@(posedge clk) disable iff (rst)
    start |-> ##(LAT) done)
    else $error("result beat missing after fixed latency");
  a_sing : assert property (@(posedge clk) disable iff (rst)
    done && singular |-> inv_r0c0 == 0 && inv_r1c1 == 0 && inv_r2c2 == 0 && det_out == 0)
    else $error("singular beat carries nonzero values");
  a_nosing : assert property (@(posedge clk) disable iff (rst)
    done && det_out != 0 |-> !singular)
    else $error("singular flagged with nonzero determinant");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// Self-checking bench for the pipelined 3x3 Q16.16 matrix inverse: matrix
// beats with random gaps, exact wide-integer prediction, field-by-field check.
// ---------------------------------------------------------------------------
module tb_matrix_inverse_3x3;

  localparam int EW   = 32;
  localparam int FB   = 16;
  localparam int LAT  = EW + 9;     // pipeline depth quoted by the block
  localparam int WDOG = 4000;       // cycles with no beat either way

  typedef logic signed [EW-1:0]  elem_t;
  typedef logic signed [255:0]   wide_t;

  // column-major element sets: m[a]*m[b] - m[c]*m[d] for each adjugate entry
  localparam int unsigned ADJ_TERMS [9][4] = '{
    '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
    '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
    '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
  };

  typedef struct {
    elem_t el [9];
  } matrix_t;

  typedef struct {
    elem_t inv [9];
    elem_t det;
    logic  sing;
  } inverse_t;

  // -------------------------------------------------------------------------
  // scoreboard: predicts the inverse of each accepted matrix and checks
  // every done beat against the oldest pending prediction
  // -------------------------------------------------------------------------
  class inverse_scoreboard;
    inverse_t pending [$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    static function elem_t clamp(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) <<< (EW - 1)) - 1;
      lo = -(wide_t'(1) <<< (EW - 1));
      if (v > hi) return elem_t'(hi);
      if (v < lo) return elem_t'(lo);
      return elem_t'(v);
    endfunction

    function void note_matrix(matrix_t m);
      wide_t    w [9];
      wide_t    adj [9];
      wide_t    dval;
      inverse_t r;
      for (int k = 0; k < 9; k++) w[k] = wide_t'(m.el[k]);
      for (int k = 0; k < 9; k++)
        adj[k] = w[ADJ_TERMS[k][0]] * w[ADJ_TERMS[k][1]]
               - w[ADJ_TERMS[k][2]] * w[ADJ_TERMS[k][3]];
      // expansion along the first row (elements 0, 3, 6)
      dval   = w[0] * adj[0] + w[3] * adj[1] + w[6] * adj[2];
      r.sing = (dval == 0);
      for (int k = 0; k < 9; k++)
        r.inv[k] = r.sing ? '0 : clamp((adj[k] <<< (2 * FB)) / dval);
      // signed divide truncates toward zero, unlike an arithmetic shift
      r.det = clamp(dval / (wide_t'(1) <<< (2 * FB)));
      pending.push_back(r);
    endfunction

    task report(string what, logic [EW-1:0] got, logic [EW-1:0] want);
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(inverse_t got);
      inverse_t want;
      if (pending.size() == 0) begin
        $display("%0t result beat with nothing pending", $realtime);
        errors++;
        return;
      end
      want = pending.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.inv[k] !== want.inv[k])
          report($sformatf("inv[%0d]", k), got.inv[k], want.inv[k]);
      if (got.det !== want.det) report("det_out", got.det, want.det);
      if (got.sing !== want.sing) report("singular", got.sing, want.sing);
    endtask
  endclass

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  elem_t a_in [9];
  wire   busy, done, singular;
  elem_t inv_o [9];
  elem_t det_out;

  inverse_scoreboard sb = new();
  int idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  matrix_inverse_3x3 #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_r0c0(a_in[0]), .a_r1c0(a_in[1]), .a_r2c0(a_in[2]),
    .a_r0c1(a_in[3]), .a_r1c1(a_in[4]), .a_r2c1(a_in[5]),
    .a_r0c2(a_in[6]), .a_r1c2(a_in[7]), .a_r2c2(a_in[8]),
    .done(done),
    .inv_r0c0(inv_o[0]), .inv_r1c0(inv_o[1]), .inv_r2c0(inv_o[2]),
    .inv_r0c1(inv_o[3]), .inv_r1c1(inv_o[4]), .inv_r2c1(inv_o[5]),
    .inv_r0c2(inv_o[6]), .inv_r1c2(inv_o[7]), .inv_r2c2(inv_o[8]),
    .det_out(det_out), .singular(singular)
  );

  // monitor: matrix beats and result beats are both taken at the rising edge
  always @(posedge clk) begin
    matrix_t  m;
    inverse_t r;
    logic     moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        m.el = a_in;
        sb.note_matrix(m);
        moved = 1'b1;
      end
      if (done) begin
        r.inv  = inv_o;
        r.det  = det_out;
        r.sing = singular;
        sb.check_result(r);
        moved = 1'b1;
      end
      if (idle_cycles >= WDOG) begin
        $display("tb_matrix_inverse_3x3: errors");
        $finish;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // drive one matrix beat, hold until taken, then leave a gap of idle cycles
  task send_matrix(matrix_t m, int gap);
    @(negedge clk);
    start <= 1'b1;
    a_in  <= m.el;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      for (int k = 0; k < 9; k++) a_in[k] <= $urandom; // junk while idle
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // stop sending and wait until every expected result has come back
  task drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 70);
  endfunction

  function automatic elem_t pick_elem(int kind);
    case (kind)
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      2: return elem_t'($signed($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 4))
          0: return {1'b1, {(EW-1){1'b0}}};
          1: return {1'b0, {(EW-1){1'b1}}};
          2: return '0;
          3: return '1;
          default: return elem_t'(1 << FB);
        endcase
      end
    endcase
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int p, kind, r0, r1;
    p    = $urandom_range(0, 99);
    kind = (p < 40) ? 1 : (p < 60) ? 0 : (p < 70) ? 2 : (p < 78) ? 3 : 1;
    for (int k = 0; k < 9; k++)
      m.el[k] = (p >= 60 && p < 70 && $urandom_range(0, 1)) ? pick_elem(1)
                                                            : pick_elem(kind);
    // a share of rank-deficient matrices: repeat a row or a column
    if (p >= 78) begin
      r0 = $urandom_range(0, 2);
      r1 = (r0 + $urandom_range(1, 2)) % 3;
      for (int c = 0; c < 3; c++)
        if (p < 90) m.el[3*c + r1] = m.el[3*c + r0];   // row copy
        else        m.el[3*r1 + c] = m.el[3*r0 + c];   // column copy
    end
    return m;
  endfunction

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int k = 0; k < 9; k++) m.el[k] = '0;
    m.el[0] = d0; m.el[4] = d1; m.el[8] = d2;
    return m;
  endfunction

  initial begin
    matrix_t m;
    elem_t   one, emax, emin;
    one  = elem_t'(1 << FB);
    emax = {1'b0, {(EW-1){1'b1}}};
    emin = {1'b1, {(EW-1){1'b0}}};
    for (int k = 0; k < 9; k++) a_in[k] = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats
    send_matrix(diag(one, one, one), 0);                 // identity
    send_matrix(diag('0, '0, '0), 0);                    // zero: singular
    send_matrix(diag(one <<< 1, -one, one >>> 1), 1);    // plain diagonal
    send_matrix(diag(32'sd1, 32'sd1, 32'sd1), 0);        // tiny det, inverse saturates
    send_matrix(diag(emax, emax, emax), 0);              // det saturates high
    send_matrix(diag(emin, emin, emin), 2);              // det saturates low
    send_matrix(diag(emin, emax, one), 0);
    send_matrix(diag(-32'sd1, one, emax), 0);
    for (int k = 0; k < 9; k++) m.el[k] = emax;
    send_matrix(m, 0);                                   // all equal: singular
    for (int k = 0; k < 9; k++) m.el[k] = emin;
    send_matrix(m, 0);
    for (int k = 0; k < 9; k++) m.el[k] = (k % 2) ? emin : emax;
    send_matrix(m, 3);
    for (int k = 0; k < 9; k++) m.el[k] = '1;
    send_matrix(m, 0);
    for (int k = 0; k < 9; k++) m.el[k] = elem_t'((k * k + 1) << (FB - 2));
    send_matrix(m, 0);
    m = diag(one, one, one); m.el[3] = one <<< 3; m.el[7] = -(one <<< 2);
    send_matrix(m, 0);                                   // triangular-ish
    m = diag(one, one, '0); m.el[6] = one;
    send_matrix(m, 0);                                   // zero row: singular
    for (int k = 0; k < 9; k++) m.el[k] = (k % 4 == 0) ? emax : 32'sd1;
    send_matrix(m, 5);
    for (int k = 0; k < 9; k++) m.el[k] = (k % 4 == 0) ? 32'sd3 : 32'sd0;
    send_matrix(m, 0);                                   // det rounds to zero, not singular

    // hold off until the pipeline has fully drained
    drain();

    // random matrices; occasional full drain mid-stream
    for (int n = 0; n < 1700; n++) begin
      send_matrix(random_matrix(), pick_gap());
      if (n % 500 == 499)
        drain();
    end

    drain();
    repeat (LAT + 20) @(posedge clk);

    if (sb.errors == 0) begin
      $display("tb_matrix_inverse_3x3: clean");
    end else begin
      $display("tb_matrix_inverse_3x3: errors");
    end
    $finish;
  end

endmodule
